// ===== hw/rtl/aarm_pkg.sv =====
// Shared types, widths and constants for the axis-angle rotation matrix unit.
// Depends on nothing; the interfaces and the top level import it.
`default_nettype none

package aarm_pkg;

	// Defaults for the top-level parameters
	localparam int FRAC_BITS_DEF       = 14;
	localparam int ANGLE_FRAC_BITS_DEF = 6;
	localparam int CORDIC_STEPS_DEF    = 16;

	// Field widths
	localparam int IN_W  = 16;
	localparam int OUT_W = 16;

	// CORDIC vector and angle width (Q2.30 with headroom)
	localparam int XY_W = 34;
	localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

	// Root bits of n2 * 2^32, and quotient bits of the normalized axis
	localparam int SQ_STEPS = 32;
	localparam int DV_STEPS = 31;
	localparam int NRM_W    = 32;

	// Side data that rides along the square root and the divider
	typedef struct packed {
		logic                  zero;
		logic [2:0]            neg;
		logic [2:0][IN_W-1:0]  mag;
	} side_t;

	// Cosine and sine after quadrant mapping
	typedef struct packed {
		logic signed [XY_W-1:0] cosv;
		logic signed [XY_W-1:0] sinv;
	} trig_t;

	// atan(2^-i) as a fraction of a full turn, 2^32 per turn
	function automatic logic [31:0] atan_turns(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			5'd24: v = 32'd41;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			5'd28: v = 32'd3;
			5'd29: v = 32'd1;
			5'd30: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/aarm_in_if.sv =====
// Input channel of the rotation matrix unit: angle and axis with valid/ready.
// Depends on aarm_pkg for the field widths.
`default_nettype none

interface aarm_in_if
	import aarm_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic signed [IN_W-1:0] angle_deg;
	logic signed [IN_W-1:0] axis_x;
	logic signed [IN_W-1:0] axis_y;
	logic signed [IN_W-1:0] axis_z;

	modport source (output valid, angle_deg, axis_x, axis_y, axis_z, input ready);
	modport sink (input valid, angle_deg, axis_x, axis_y, axis_z, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/aarm_out_if.sv =====
// Output channel of the rotation matrix unit: nine entries and a zero-axis flag.
// Depends on aarm_pkg for the field widths.
`default_nettype none

interface aarm_out_if
	import aarm_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] m_r0c0;
	logic signed [OUT_W-1:0] m_r0c1;
	logic signed [OUT_W-1:0] m_r0c2;
	logic signed [OUT_W-1:0] m_r1c0;
	logic signed [OUT_W-1:0] m_r1c1;
	logic signed [OUT_W-1:0] m_r1c2;
	logic signed [OUT_W-1:0] m_r2c0;
	logic signed [OUT_W-1:0] m_r2c1;
	logic signed [OUT_W-1:0] m_r2c2;
	logic                    zero_axis;

	modport source (output valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
		m_r2c0, m_r2c1, m_r2c2, zero_axis, input ready);
	modport sink (input valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
		m_r2c0, m_r2c1, m_r2c2, zero_axis, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/axis_angle_rotation_matrix_unit.sv =====
// Rotation matrix unit top level: angle reduction, CORDIC, axis normalization, products.
// Depends on aarm_pkg, aarm_in_if and aarm_out_if.
//
// One item enters per clock unless the output stalls; the pipeline depth comes from
// the square root (one root bit per stage, 32 stages) followed by the divider that
// normalizes the axis (one quotient bit per stage, 31 stages), with the CORDIC running
// alongside. The whole pipeline advances together: when the output holds an untaken
// result, every stage holds and the input is not ready, so nothing is lost or repeated.
// The angle wraps modulo 360 degrees. An all-zero axis yields the identity with
// zero_axis set.
`default_nettype none

module axis_angle_rotation_matrix_unit
	import aarm_pkg::*;
#(
	parameter int FRAC_BITS       = FRAC_BITS_DEF,
	parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
	parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	aarm_in_if.sink    in_ch,
	aarm_out_if.source out_ch
);

	// Angle period and its reciprocal, 2^48 / period
	localparam int PERIOD  = 360 << ANGLE_FRAC_BITS;
	localparam int PER_W   = $clog2(PERIOD + 1);
	localparam int REM_W   = PER_W + 2;
	localparam logic [63:0] RECIP = (64'd1 << 48) / 64'(PERIOD);
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int APROD_W = IN_W + RECIP_W + 1;
	localparam logic [RECIP_W-1:0] RECIP_C  = RECIP_W'(RECIP);
	localparam logic [REM_W-1:0]   PERIOD_C = REM_W'(PERIOD);

	// Stage map
	localparam int S_PH  = 3;
	localparam int S_SQ  = S_PH + SQ_STEPS - 1;
	localparam int S_U   = S_SQ + DV_STEPS;
	localparam int S_TR  = S_PH + 1 + CORDIC_STEPS;
	localparam int S_OUT = S_U + 4;

	// Root width and result rounding
	localparam int RT_W = 36;
	localparam int SH   = 60 - FRAC_BITS;
	localparam logic signed [63:0] RND    = 64'sd1 <<< (SH - 1);
	localparam logic signed [63:0] ONE_FB = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [XY_W:0] ONE_Q30 = (XY_W + 1)'(1) <<< 30;
	localparam logic signed [63:0] P_RND = 64'sd1 <<< 29;
	localparam logic signed [OUT_W-1:0] LIM = OUT_W'(1 << FRAC_BITS);

	// Quadrant codes
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	// Symmetric product pairs, and for each entry its pair, cross term and sign
	localparam int PR_ROW [6] = '{0, 0, 0, 1, 1, 2};
	localparam int PR_COL [6] = '{0, 1, 2, 1, 2, 2};
	localparam int PIDX   [9] = '{0, 1, 2, 1, 3, 4, 2, 4, 5};
	localparam int KU     [9] = '{0, 2, 1, 2, 0, 0, 1, 0, 0};
	localparam int KSGN   [9] = '{0, -1, 1, 1, 0, -1, -1, 1, 0};

	logic adv;
	logic vld_s [1:S_OUT];

	// Advance all stages when the output register is free or being taken
	assign adv          = !vld_s[S_OUT] || out_ch.ready;
	assign in_ch.ready  = adv;
	assign out_ch.valid = vld_s[S_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= S_OUT; k++) vld_s[k] <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= in_ch.valid;
			for (int k = 2; k <= S_OUT; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// ---------------- front: angle scaling, squares, side data
	logic signed [IN_W-1:0]    ax_in [3];
	logic signed [2*IN_W-1:0]  sqp   [3];
	side_t                     side_in;
	logic signed [APROD_W-1:0] aprod_s1;
	logic [31:0]               sq_s1 [3];
	side_t                     side_s [1:S_U];

	assign ax_in[0] = in_ch.axis_x;
	assign ax_in[1] = in_ch.axis_y;
	assign ax_in[2] = in_ch.axis_z;

	always_comb begin
		side_in.zero = (ax_in[0] == '0) && (ax_in[1] == '0) && (ax_in[2] == '0);
		for (int j = 0; j < 3; j++) begin
			sqp[j]            = ax_in[j] * ax_in[j];
			side_in.neg[j]    = ax_in[j][IN_W-1];
			side_in.mag[j]    = ax_in[j][IN_W-1] ? IN_W'(-ax_in[j]) : ax_in[j];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			aprod_s1 <= in_ch.angle_deg * signed'({1'b0, RECIP_C});
			for (int j = 0; j < 3; j++) sq_s1[j] <= sqp[j];
			side_s[1] <= side_in;
			for (int k = 2; k <= S_U; k++) side_s[k] <= side_s[k-1];
		end
	end

	// ---------------- stage 2: quotient estimate and its low remainder bits
	logic [31:0]      qe_w;
	logic [REM_W-1:0] qe_lo;
	logic [31:0]      qe_s2;
	logic [REM_W-1:0] lp_s2;
	logic [31:0]      n2_s2;

	assign qe_w  = 32'(aprod_s1 >>> 16);
	assign qe_lo = qe_w[REM_W-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			qe_s2 <= qe_w;
			lp_s2 <= qe_lo * PERIOD_C;
			n2_s2 <= sq_s1[0] + sq_s1[1] + sq_s1[2];
		end
	end

	// ---------------- stage 3: correct the estimate to the exact phase
	logic signed [REM_W-1:0] prem;
	logic [31:0]             phase_nx;
	logic [31:0]             phase_s3;

	assign prem = signed'(REM_W'(0) - lp_s2);

	always_comb begin
		if (prem < 0) begin
			phase_nx = qe_s2 - 32'd1;
		end else if (prem >= signed'(PERIOD_C)) begin
			phase_nx = qe_s2 + 32'd1;
		end else begin
			phase_nx = qe_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) phase_s3 <= phase_nx;
	end

	// ---------------- square root, one root bit per stage (stages 3 .. 34)
	logic [RT_W-1:0] rt_rem_s  [SQ_STEPS];
	logic [31:0]     rt_root_s [SQ_STEPS];
	logic [31:0]     rt_rad_s  [SQ_STEPS];

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_rt
		logic [RT_W-1:0] rem_i;
		logic [RT_W-1:0] cat;
		logic [RT_W-1:0] trial;
		logic [31:0]     root_i;
		logic [31:0]     rad_i;
		logic            ge;

		if (k == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign rad_i  = n2_s2;
		end else begin : g_next
			assign rem_i  = rt_rem_s[k-1];
			assign root_i = rt_root_s[k-1];
			assign rad_i  = rt_rad_s[k-1];
		end

		assign cat   = {rem_i[RT_W-3:0], rad_i[31:30]};
		assign trial = RT_W'({root_i, 2'b01});
		assign ge    = cat >= trial;

		always_ff @(posedge clk) begin
			if (adv) begin
				rt_rem_s[k]  <= ge ? cat - trial : cat;
				rt_root_s[k] <= {root_i[30:0], ge};
				rt_rad_s[k]  <= {rad_i[29:0], 2'b00};
			end
		end
	end

	// ---------------- divider, one quotient bit per stage (stages 35 .. 65)
	logic [31:0]         dv_div_s [DV_STEPS];
	logic [31:0]         dv_rem_s [DV_STEPS][3];
	logic [DV_STEPS-1:0] dv_q_s   [DV_STEPS][3];

	for (genvar k = 0; k < DV_STEPS; k++) begin : g_dv
		logic [31:0] div_i;
		logic [31:0] rem_i [3];
		logic [DV_STEPS-1:0] q_i [3];

		if (k == 0) begin : g_first
			assign div_i = rt_root_s[SQ_STEPS-1];
			for (genvar j = 0; j < 3; j++) begin : g_ln
				assign rem_i[j] = {1'b0, side_s[S_SQ].mag[j], 15'b0};
				assign q_i[j]   = '0;
			end
		end else begin : g_next
			assign div_i = dv_div_s[k-1];
			for (genvar j = 0; j < 3; j++) begin : g_ln
				assign rem_i[j] = dv_rem_s[k-1][j];
				assign q_i[j]   = dv_q_s[k-1][j];
			end
		end

		for (genvar j = 0; j < 3; j++) begin : g_lane
			logic [32:0] cat;
			logic        ge;

			// Bring down the next bit of the rounding term s/2
			assign cat = {rem_i[j], div_i[31-k]};
			assign ge  = cat >= {1'b0, div_i};

			always_ff @(posedge clk) begin
				if (adv) begin
					dv_rem_s[k][j] <= ge ? 32'(cat - {1'b0, div_i}) : cat[31:0];
					dv_q_s[k][j]   <= {q_i[j][DV_STEPS-2:0], ge};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) dv_div_s[k] <= div_i;
		end
	end

	// ---------------- CORDIC, one micro-rotation per stage
	logic signed [XY_W-1:0] cx_s [CORDIC_STEPS];
	logic signed [XY_W-1:0] cy_s [CORDIC_STEPS];
	logic signed [XY_W-1:0] cz_s [CORDIC_STEPS];
	logic [1:0]             cq_s [CORDIC_STEPS];

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cr
		logic signed [XY_W-1:0] x_i;
		logic signed [XY_W-1:0] y_i;
		logic signed [XY_W-1:0] z_i;
		logic [1:0]             q_i;
		logic signed [XY_W-1:0] dx;
		logic signed [XY_W-1:0] dy;
		logic signed [XY_W-1:0] at;

		if (k == 0) begin : g_first
			assign x_i = CORDIC_GAIN;
			assign y_i = '0;
			assign z_i = signed'(XY_W'(phase_s3[29:0]));
			assign q_i = phase_s3[31:30];
		end else begin : g_next
			assign x_i = cx_s[k-1];
			assign y_i = cy_s[k-1];
			assign z_i = cz_s[k-1];
			assign q_i = cq_s[k-1];
		end

		assign dx = y_i >>> k;
		assign dy = x_i >>> k;
		assign at = signed'(XY_W'(atan_turns(5'(k))));

		always_ff @(posedge clk) begin
			if (adv) begin
				if (!z_i[XY_W-1]) begin
					cx_s[k] <= x_i - dx;
					cy_s[k] <= y_i + dy;
					cz_s[k] <= z_i - at;
				end else begin
					cx_s[k] <= x_i + dx;
					cy_s[k] <= y_i - dy;
					cz_s[k] <= z_i + at;
				end
				cq_s[k] <= q_i;
			end
		end
	end

	// Map the quadrant, then hold cosine and sine until the axis is normalized
	trig_t trig_nx;
	trig_t trig_s [S_TR:S_U];

	always_comb begin
		case (cq_s[CORDIC_STEPS-1])
			QUAD_0: begin
				trig_nx.cosv = cx_s[CORDIC_STEPS-1];
				trig_nx.sinv = cy_s[CORDIC_STEPS-1];
			end
			QUAD_1: begin
				trig_nx.cosv = -cy_s[CORDIC_STEPS-1];
				trig_nx.sinv = cx_s[CORDIC_STEPS-1];
			end
			QUAD_2: begin
				trig_nx.cosv = -cx_s[CORDIC_STEPS-1];
				trig_nx.sinv = -cy_s[CORDIC_STEPS-1];
			end
			QUAD_3: begin
				trig_nx.cosv = cy_s[CORDIC_STEPS-1];
				trig_nx.sinv = -cx_s[CORDIC_STEPS-1];
			end
			default: begin
				trig_nx.cosv = cx_s[CORDIC_STEPS-1];
				trig_nx.sinv = cy_s[CORDIC_STEPS-1];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			trig_s[S_TR] <= trig_nx;
			for (int t = S_TR + 1; t <= S_U; t++) trig_s[t] <= trig_s[t-1];
		end
	end

	// ---------------- stage 66: signed unit axis and u*u^T products
	logic signed [NRM_W-1:0] u_w    [3];
	logic signed [63:0]      pp_w   [6];
	logic signed [NRM_W-1:0] p_s66  [6];
	logic signed [NRM_W-1:0] u_s66  [3];
	trig_t                   trig_s66;
	logic                    zero_s66;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			u_w[j] = side_s[S_U].neg[j] ? -signed'({1'b0, dv_q_s[DV_STEPS-1][j]})
				: signed'({1'b0, dv_q_s[DV_STEPS-1][j]});
		end
		for (int n = 0; n < 6; n++) pp_w[n] = u_w[PR_ROW[n]] * u_w[PR_COL[n]];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int n = 0; n < 6; n++) p_s66[n] <= NRM_W'((pp_w[n] + P_RND) >>> 30);
			for (int j = 0; j < 3; j++) u_s66[j] <= u_w[j];
			trig_s66 <= trig_s[S_U];
			zero_s66 <= side_s[S_U].zero;
		end
	end

	// ---------------- stage 67: (1 - cos) * p and sin * u
	logic signed [XY_W:0]   omc_w;
	logic signed [63:0]     t1_s67 [6];
	logic signed [63:0]     t2_s67 [3];
	logic signed [XY_W-1:0] cos_s67;
	logic                   zero_s67;

	assign omc_w = ONE_Q30 - trig_s66.cosv;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int n = 0; n < 6; n++) t1_s67[n] <= omc_w * p_s66[n];
			for (int j = 0; j < 3; j++) t2_s67[j] <= trig_s66.sinv * u_s66[j];
			cos_s67  <= trig_s66.cosv;
			zero_s67 <= zero_s66;
		end
	end

	// ---------------- stage 68: sum the three terms of each entry
	logic signed [63:0] acc_s68 [9];
	logic               zero_s68;

	for (genvar e = 0; e < 9; e++) begin : g_acc
		logic signed [63:0] kt;
		logic signed [63:0] dg;

		if (KSGN[e] > 0) begin : g_pos
			assign kt = t2_s67[KU[e]];
		end else if (KSGN[e] < 0) begin : g_neg
			assign kt = -t2_s67[KU[e]];
		end else begin : g_none
			assign kt = '0;
		end

		if (e % 4 == 0) begin : g_diag
			assign dg = 64'(cos_s67) <<< 30;
		end else begin : g_off
			assign dg = '0;
		end

		always_ff @(posedge clk) begin
			if (adv) acc_s68[e] <= t1_s67[PIDX[e]] + kt + dg;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) zero_s68 <= zero_s67;
	end

	// ---------------- output register: round, saturate, identity for a zero axis
	logic signed [63:0] rnd_w [9];
	logic [OUT_W-1:0]   ent_w [9];
	logic [OUT_W-1:0]   mat_q [9];
	logic               zero_q;

	always_comb begin
		for (int e = 0; e < 9; e++) begin
			rnd_w[e] = (acc_s68[e] + RND) >>> SH;
			if (zero_s68) begin
				ent_w[e] = (e % 4 == 0) ? OUT_W'(ONE_FB) : '0;
			end else if (rnd_w[e] > ONE_FB) begin
				ent_w[e] = OUT_W'(ONE_FB);
			end else if (rnd_w[e] < -ONE_FB) begin
				ent_w[e] = OUT_W'(-ONE_FB);
			end else begin
				ent_w[e] = OUT_W'(rnd_w[e]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int e = 0; e < 9; e++) mat_q[e] <= ent_w[e];
			zero_q <= zero_s68;
		end
	end

	assign out_ch.m_r0c0    = mat_q[0];
	assign out_ch.m_r0c1    = mat_q[1];
	assign out_ch.m_r0c2    = mat_q[2];
	assign out_ch.m_r1c0    = mat_q[3];
	assign out_ch.m_r1c1    = mat_q[4];
	assign out_ch.m_r1c2    = mat_q[5];
	assign out_ch.m_r2c0    = mat_q[6];
	assign out_ch.m_r2c1    = mat_q[7];
	assign out_ch.m_r2c2    = mat_q[8];
	assign out_ch.zero_axis = zero_q;

	// ---------------- checks
	logic all_in_range;

	always_comb begin
		all_in_range = 1'b1;
		if (FRAC_BITS <= 14) begin
			for (int e = 0; e < 9; e++) begin
				if (signed'(mat_q[e]) > LIM || signed'(mat_q[e]) < -LIM) all_in_range = 1'b0;
			end
		end
	end

	// The reciprocal estimate is never off by more than one period
	a_phase_est: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[2] |-> prem >= -signed'(PERIOD_C) && prem < signed'(PERIOD_C << 1))
		else $error("angle quotient estimate out of range");

	// A unit axis component never exceeds one
	a_unit_axis: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[S_U] && !side_s[S_U].zero |->
			dv_q_s[DV_STEPS-1][0] <= 31'd1073741824 &&
			dv_q_s[DV_STEPS-1][1] <= 31'd1073741824 &&
			dv_q_s[DV_STEPS-1][2] <= 31'd1073741824)
		else $error("normalized axis component above one");

	// A zero axis leaves as the identity
	a_zero_ident: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[S_OUT] && zero_q |->
			mat_q[0] == OUT_W'(ONE_FB) && mat_q[4] == OUT_W'(ONE_FB) &&
			mat_q[8] == OUT_W'(ONE_FB) && mat_q[1] == '0 && mat_q[5] == '0)
		else $error("zero axis did not give identity");

	// Entries stay within plus or minus one
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[S_OUT] |-> all_in_range)
		else $error("matrix entry outside saturation range");

	// A held result freezes the input side
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[S_OUT] && !out_ch.ready |-> !in_ch.ready)
		else $error("input accepted while output stalled");

endmodule

`default_nettype wire
